/* rtl/q2e_pkg.sv */
`default_nettype none
package q2e_pkg;
  localparam int FRAC_MID = 28;
  localparam int MID_W = 34;
  localparam int CW = 40;
  localparam int AW = 34;
  localparam logic signed [AW-1:0] ANG_PI = 34'sd3373259426;
  localparam logic signed [15:0] OUT_PI = 16'sd25736;
  localparam logic signed [15:0] OUT_HALF_PI = 16'sd12868;
  localparam logic signed [15:0] OUT_HALF_PI_N = -16'sd12868;
  localparam logic signed [15:0] OUT_PI_N = -16'sd25736;

  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
  } cvec_t;
endpackage
`default_nettype wire

/* rtl/q2e_cordic.sv */
`default_nettype none
module q2e_cordic import q2e_pkg::*; #(
  parameter int STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic signed [CW-1:0] in_y,
  input  wire logic signed [CW-1:0] in_x,
  input  wire logic signed [15:0] lim,
  output logic out_valid,
  output logic signed [15:0] angle
);
  cvec_t st [STAGES+1];
  logic [STAGES:0] vld;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] lim_w;
  logic signed [15:0] lim_q [STAGES+1];

  // Pre-rotation by pi puts the vector in the right half plane.
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
    lim_q[0] <= lim;
    if (in_x < 0) begin
      st[0].x <= -in_x;
      st[0].y <= -in_y;
      st[0].z <= (in_y >= 0) ? ANG_PI : -ANG_PI;
    end else begin
      st[0].x <= in_x;
      st[0].y <= in_y;
      st[0].z <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
      lim_q[i+1] <= lim_q[i];
      if (st[i].y >= 0) begin
        st[i+1].x <= st[i].x + (st[i].y >>> (i % 32));
        st[i+1].y <= st[i].y - (st[i].x >>> (i % 32));
        st[i+1].z <= st[i].z + atan_entry(i % 32);
      end else begin
        st[i+1].x <= st[i].x - (st[i].y >>> (i % 32));
        st[i+1].y <= st[i].y + (st[i].x >>> (i % 32));
        st[i+1].z <= st[i].z - atan_entry(i % 32);
      end
    end
  end

  assign rnd = (st[STAGES].z + AW'(65536)) >>> 17;
  assign lim_w = AW'(lim_q[STAGES]);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vld[STAGES];
    if (rnd > lim_w) angle <= lim_q[STAGES];
    else if (rnd < -lim_w) angle <= -lim_q[STAGES];
    else angle <= rnd[15:0];
  end
endmodule
`default_nettype wire

/* rtl/q2e_front.sv */
`default_nettype none
module q2e_front import q2e_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic signed [WIDTH-1:0] qw,
  input  wire logic signed [WIDTH-1:0] qx,
  input  wire logic signed [WIDTH-1:0] qy,
  input  wire logic signed [WIDTH-1:0] qz,
  output logic out_valid,
  output logic signed [CW-1:0] sr,
  output logic signed [CW-1:0] cr,
  output logic signed [CW-1:0] sy,
  output logic signed [CW-1:0] cy,
  output logic signed [CW-1:0] sp,
  output logic sp_sat
);
  localparam int FI = WIDTH - 2;
  localparam int PW = 2 * WIDTH;
  localparam logic signed [MID_W-1:0] ONE = MID_W'(1) <<< FRAC_MID;

  logic signed [PW-1:0] p [9];
  logic v1, v2;
  logic signed [MID_W-1:0] a_sr, a_cr, a_sy, a_cy, a_sp;

  function automatic logic signed [MID_W-1:0] scl(input logic signed [PW-1:0] v);
    logic signed [PW+MID_W-1:0] e;
    e = (PW+MID_W)'(v);
    if (2 * FI >= FRAC_MID) e = e >>> (2 * FI - FRAC_MID);
    else e = e <<< (FRAC_MID - 2 * FI);
    return e[MID_W-1:0];
  endfunction

  // Stage one: nine products; stage two: rescale and combine.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    p[0] <= PW'(qw) * PW'(qx);
    p[1] <= PW'(qy) * PW'(qz);
    p[2] <= PW'(qx) * PW'(qx);
    p[3] <= PW'(qy) * PW'(qy);
    p[4] <= PW'(qw) * PW'(qy);
    p[5] <= PW'(qz) * PW'(qx);
    p[6] <= PW'(qw) * PW'(qz);
    p[7] <= PW'(qx) * PW'(qy);
    p[8] <= PW'(qz) * PW'(qz);
    a_sr <= (scl(p[0]) + scl(p[1])) <<< 1;
    a_cr <= ONE - ((scl(p[2]) + scl(p[3])) <<< 1);
    a_sp <= (scl(p[4]) - scl(p[5])) <<< 1;
    a_sy <= (scl(p[6]) + scl(p[7])) <<< 1;
    a_cy <= ONE - ((scl(p[3]) + scl(p[8])) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v2;
    sr <= CW'(a_sr);
    cr <= CW'(a_cr);
    sy <= CW'(a_sy);
    cy <= CW'(a_cy);
    sp <= CW'(a_sp);
    sp_sat <= (a_sp >= ONE) || (a_sp <= -ONE);
  end
endmodule
`default_nettype wire

/* rtl/q2e_sqrt.sv */
`default_nettype none
module q2e_sqrt import q2e_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic signed [CW-1:0] sp,
  input  wire logic sat,
  output logic out_valid,
  output logic signed [CW-1:0] sp_out,
  output logic signed [CW-1:0] root,
  output logic sat_out
);
  // Pitch cosine term: isqrt(2^56 - sp^2), one result bit per stage.
  localparam int RB = 29;
  localparam int VW = 58;
  localparam int NS = 3;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [VW-1:0] r;
    logic signed [CW-1:0] s;
    logic sat;
  } sq_t;

  sq_t st [RB+NS+1];
  logic [RB+NS:0] vld;
  logic [31:0] a_lo, pa;
  logic [VW-1:0] p_ll, p_lh, p_hh;
  logic [28:0] mag;
  logic [28:0] mag_q;

  assign mag = (sp < 0) ? 29'(-sp) : 29'(sp);

  // Square of the magnitude split into three partial products.
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
    st[0].s <= sp;
    st[0].sat <= sat;
    mag_q <= sat ? '0 : mag;
    st[0].v <= '0;
    st[0].r <= '0;
  end
  assign a_lo = {17'd0, mag_q[14:0]};
  assign pa = {18'd0, mag_q[28:15]};
  always_ff @(posedge clk) begin
    if (rst) vld[1] <= 1'b0;
    else vld[1] <= vld[0];
    st[1] <= st[0];
    p_ll <= VW'(a_lo * a_lo);
    p_lh <= VW'(a_lo * pa);
    p_hh <= VW'(pa * pa);
  end
  always_ff @(posedge clk) begin
    if (rst) vld[2] <= 1'b0;
    else vld[2] <= vld[1];
    st[2].s <= st[1].s;
    st[2].sat <= st[1].sat;
    st[2].r <= '0;
    st[2].v <= (VW'(1) << 56) - ((p_hh << 30) + (p_lh << 16) + p_ll);
  end
  assign st[3] = st[2];
  assign vld[3] = vld[2];

  for (genvar i = 0; i < RB; i++) begin : g_bit
    localparam logic [VW-1:0] BIT = VW'(1) << (2 * (RB - 1 - i));
    always_ff @(posedge clk) begin
      if (rst) vld[NS+i+1] <= 1'b0;
      else vld[NS+i+1] <= vld[NS+i];
      st[NS+i+1].s <= st[NS+i].s;
      st[NS+i+1].sat <= st[NS+i].sat;
      if (st[NS+i].v >= st[NS+i].r + BIT) begin
        st[NS+i+1].v <= st[NS+i].v - (st[NS+i].r + BIT);
        st[NS+i+1].r <= (st[NS+i].r >> 1) + BIT;
      end else begin
        st[NS+i+1].v <= st[NS+i].v;
        st[NS+i+1].r <= st[NS+i].r >> 1;
      end
    end
  end

  assign out_valid = vld[RB+NS];
  assign sp_out = st[RB+NS].s;
  assign root = CW'(st[RB+NS].r);
  assign sat_out = st[RB+NS].sat;
endmodule
`default_nettype wire

/* rtl/quaternion_to_euler_top.sv */
`default_nettype none
// Channel  | Handshake       | Payload
// input    | start, busy     | qw, qx, qy, qz
// result   | done (strobe)   | roll, pitch, yaw, pitch_clamped
//
// One quaternion transfer is taken each cycle; busy is always low.
// Pipeline: 3 front stages, 32 square root stages, CORDIC_STAGES + 2 CORDIC stages.
// Roll and yaw are delayed to line up with the pitch path.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
// The receiver cannot stall, so results leave on done for one cycle.
module quaternion_to_euler_top import q2e_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic signed [COMPONENT_WIDTH-1:0] qw,
  input  wire logic signed [COMPONENT_WIDTH-1:0] qx,
  input  wire logic signed [COMPONENT_WIDTH-1:0] qy,
  input  wire logic signed [COMPONENT_WIDTH-1:0] qz,
  output logic done,
  output logic signed [15:0] roll,
  output logic signed [14:0] pitch,
  output logic signed [15:0] yaw,
  output logic pitch_clamped
);
  localparam int DLY = 32;

  logic f_v;
  logic signed [CW-1:0] sr, cr, sy, cy, sp;
  logic sat;
  logic signed [CW-1:0] sr_d [DLY+1];
  logic signed [CW-1:0] cr_d [DLY+1];
  logic signed [CW-1:0] sy_d [DLY+1];
  logic signed [CW-1:0] cy_d [DLY+1];
  logic q_v, q_sat;
  logic signed [CW-1:0] q_sp, q_root;
  logic r_v, y_v, p_v;
  logic signed [15:0] r_ang, y_ang, p_ang;
  logic [CORDIC_STAGES+2:0] sat_d;
  logic [CORDIC_STAGES+2:0] neg_d;

  assign busy = 1'b0;

  q2e_front #(.WIDTH(COMPONENT_WIDTH)) u_front (
    .clk, .rst, .in_valid(start), .qw, .qx, .qy, .qz,
    .out_valid(f_v), .sr, .cr, .sy, .cy, .sp, .sp_sat(sat)
  );

  q2e_sqrt u_sqrt (
    .clk, .rst, .in_valid(f_v), .sp, .sat,
    .out_valid(q_v), .sp_out(q_sp), .root(q_root), .sat_out(q_sat)
  );

  // Delay line that holds the roll and yaw operands beside the root.
  assign sr_d[0] = sr;
  assign cr_d[0] = cr;
  assign sy_d[0] = sy;
  assign cy_d[0] = cy;
  for (genvar i = 0; i < DLY; i++) begin : g_dly
    always_ff @(posedge clk) begin
      sr_d[i+1] <= sr_d[i];
      cr_d[i+1] <= cr_d[i];
      sy_d[i+1] <= sy_d[i];
      cy_d[i+1] <= cy_d[i];
    end
  end

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk, .rst, .in_valid(q_v), .in_y(sr_d[DLY]), .in_x(cr_d[DLY]), .lim(OUT_PI),
    .out_valid(r_v), .angle(r_ang)
  );
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk, .rst, .in_valid(q_v), .in_y(sy_d[DLY]), .in_x(cy_d[DLY]), .lim(OUT_PI),
    .out_valid(y_v), .angle(y_ang)
  );
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk, .rst, .in_valid(q_v), .in_y(q_sp), .in_x(q_root), .lim(OUT_HALF_PI),
    .out_valid(p_v), .angle(p_ang)
  );

  // The clamp flag and sign ride beside the pitch CORDIC in a shift register
  // with one register for each of its pipeline stages.
  assign sat_d[0] = q_sat;
  assign neg_d[0] = q_sp[CW-1];
  always_ff @(posedge clk) begin
    sat_d[CORDIC_STAGES+2:1] <= sat_d[CORDIC_STAGES+1:0];
    neg_d[CORDIC_STAGES+2:1] <= neg_d[CORDIC_STAGES+1:0];
  end

  always_comb begin
    done = r_v & y_v & p_v;
    roll = r_ang;
    yaw = y_ang;
    pitch_clamped = sat_d[CORDIC_STAGES+2];
    if (pitch_clamped) begin
      pitch = neg_d[CORDIC_STAGES+2] ? OUT_HALF_PI_N[14:0] : OUT_HALF_PI[14:0];
    end else begin
      pitch = p_ang[14:0];
    end
  end
endmodule
`default_nettype wire

/* rtl/quaternion_to_euler_checker.sv */
`default_nettype none
module quaternion_to_euler_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic signed [15:0] roll,
  input wire logic signed [14:0] pitch,
  input wire logic signed [15:0] yaw,
  input wire logic pitch_clamped
);
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_roll: assert property (@(posedge clk) disable iff (rst)
    done |-> (roll <= 16'sd25736 && roll >= -16'sd25736)) else $error("roll range");
  a_yaw: assert property (@(posedge clk) disable iff (rst)
    done |-> (yaw <= 16'sd25736 && yaw >= -16'sd25736)) else $error("yaw range");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    done && pitch_clamped |-> (pitch == 15'sd12868 || pitch == -15'sd12868))
    else $error("clamp value");
  a_rst: assert property (@(posedge clk) rst |=> !done) else $error("done after reset");
endmodule

bind quaternion_to_euler_top quaternion_to_euler_checker u_chk (
  .clk, .rst, .start, .busy, .done, .roll, .pitch, .yaw, .pitch_clamped
);
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
// Self-checking bench for the quaternion to Euler angle converter.
// A queue of quaternions is filled up front: a directed set of corner cases,
// then random unit and non-unit quaternions. The driver pushes one transfer
// per cycle with random gaps. For every accepted transfer a bit-exact angle
// predictor computes roll, pitch, yaw and the clamp flag. The monitor compares
// each done strobe against the oldest prediction.
module tb;
  import q2e_pkg::*;

  localparam int QW = 16;
  localparam int STAGES = 16;
  localparam int LATENCY = 3 + 32 + STAGES + 2;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic clamped;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [QW-1:0] qw = '0, qx = '0, qy = '0, qz = '0;
  logic busy, done, pitch_clamped;
  logic signed [15:0] roll, yaw;
  logic signed [14:0] pitch;

  quaternion_to_euler_top #(.COMPONENT_WIDTH(QW), .CORDIC_STAGES(STAGES)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz),
    .done(done), .roll(roll), .pitch(pitch), .yaw(yaw),
    .pitch_clamped(pitch_clamped)
  );

  quat_t pending_quats[$];
  euler_t expected_angles[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_until_drained = 0;  // index at which the driver waits for results
  int sent = 0;
  bit calm_stretch = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Arithmetic shift right with floor rounding, done on 64-bit signed values.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Product of two Q1.14 values rescaled to 28 fraction bits.
  function automatic longint prod28(longint a, longint b);
    return (a * b) <<< (28 - 2 * (QW - 2));
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(r);
  endfunction

  // Vectoring CORDIC angle of (y, x), rounded half up to Q3.13 and clamped.
  function automatic longint vector_angle(longint y, longint x, longint lim);
    longint acc, dx, dy, r;
    acc = 0;
    if (x < 0) begin
      acc = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; acc += longint'(atan_entry(i));
      end else begin
        x -= dx; y += dy; acc -= longint'(atan_entry(i));
      end
    end
    r = shr_floor(acc + (64'sd1 <<< 16), 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t predict_angles(quat_t q);
    longint w, x, y, z, unity, sr, cr, sp, sy, cy, p;
    longint unsigned rem;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    unity = 64'sd1 <<< 28;
    sr = 2 * (prod28(w, x) + prod28(y, z));
    cr = unity - 2 * (prod28(x, x) + prod28(y, y));
    sp = 2 * (prod28(w, y) - prod28(z, x));
    sy = 2 * (prod28(w, z) + prod28(x, y));
    cy = unity - 2 * (prod28(y, y) + prod28(z, z));
    e.roll = 16'(vector_angle(sr, cr, 25736));
    e.yaw = 16'(vector_angle(sy, cy, 25736));
    if (sp >= unity || sp <= -unity) begin
      p = (sp > 0) ? 12868 : -12868;
      e.clamped = 1'b1;
    end else begin
      rem = (64'd1 << 56) - longint'(sp * sp);
      p = vector_angle(sp, int_sqrt(rem), 12868);
      e.clamped = 1'b0;
    end
    e.pitch = 15'(p);
    return e;
  endfunction

  function automatic quat_t mkq(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    return q;
  endfunction

  // Random roughly unit quaternion: components drawn, then scaled by the
  // norm so most items sit near the unit sphere.
  function automatic quat_t random_unit();
    real a, b, c, d, n;
    a = $itor($signed($urandom_range(0, 32768)) - 16384);
    b = $itor($signed($urandom_range(0, 32768)) - 16384);
    c = $itor($signed($urandom_range(0, 32768)) - 16384);
    d = $itor($signed($urandom_range(0, 32768)) - 16384);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) return mkq(16384, 0, 0, 0);
    return mkq($rtoi(a * 16384.0 / n), $rtoi(b * 16384.0 / n),
               $rtoi(c * 16384.0 / n), $rtoi(d * 16384.0 / n));
  endfunction

  initial begin
    int h;
    // Directed corner cases: identity, zero vector, gimbal lock both ways,
    // half turns (negative real operand, zero imaginary part), extremes.
    pending_quats.push_back(mkq(16384, 0, 0, 0));
    pending_quats.push_back(mkq(0, 0, 0, 0));
    pending_quats.push_back(mkq(11585, 0, 11585, 0));
    pending_quats.push_back(mkq(11585, 0, -11585, 0));
    pending_quats.push_back(mkq(16384, 0, 16384, 0));
    pending_quats.push_back(mkq(0, 16384, 0, 0));
    pending_quats.push_back(mkq(0, 0, 0, 16384));
    pending_quats.push_back(mkq(0, 0, 16384, 0));
    pending_quats.push_back(mkq(-16384, 0, 0, 0));
    pending_quats.push_back(mkq(16384, 16384, 16384, 16384));
    pending_quats.push_back(mkq(-16384, -16384, -16384, -16384));
    pending_quats.push_back(mkq(32767, 32767, 32767, 32767));
    pending_quats.push_back(mkq(-32768, -32768, -32768, -32768));
    pending_quats.push_back(mkq(32767, -32768, 32767, -32768));
    pending_quats.push_back(mkq(11585, 11585, 0, 0));
    pending_quats.push_back(mkq(11585, 0, 0, -11585));
    pending_quats.push_back(mkq(8192, 8192, 8192, -8192));
    pending_quats.push_back(mkq(0, 11585, 0, 11585));
    pending_quats.push_back(mkq(1, -1, 1, -1));
    // Random part: mostly unit quaternions, some raw full-range patterns.
    for (int i = 0; i < 1800; i++) begin
      if ($urandom_range(0, 99) < 80) pending_quats.push_back(random_unit());
      else begin
        h = $urandom;
        pending_quats.push_back(mkq(h[15:0], h[31:16], $urandom, $urandom));
      end
    end
    hold_until_drained = 900;
  end

  // Driver: one transfer per accepted cycle, with random gaps except in a
  // calm stretch, and one full drain pause half way through. The count used
  // for the pause includes a transfer accepted at this edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 12) rst <= 1'b0;
    if (cycles == 400) calm_stretch <= 1'b1;
    if (cycles == 700) calm_stretch <= 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        expected_angles.push_back(predict_angles({qw, qx, qy, qz}));
        sent <= sent + 1;
      end
      if (!(start && busy)) begin
        if (pending_quats.size() > 0 &&
            !((sent + ((start && !busy) ? 1 : 0)) == hold_until_drained &&
              expected_angles.size() != 0) &&
            (calm_stretch || $urandom_range(0, 99) >= 22)) begin
          {qw, qx, qy, qz} <= pending_quats.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe is a result transfer checked field by field.
  always @(posedge clk) begin
    euler_t got, exp_e;
    if (!rst && done) begin
      got = '{roll, pitch, yaw, pitch_clamped};
      if (expected_angles.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result transfer %p", got);
      end else begin
        exp_e = expected_angles.pop_front();
        if (got !== exp_e) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %p, got %p", exp_e, got);
        end
      end
    end
  end

  initial begin
    int settle;
    settle = 0;
    while (!(cycles > 20 && pending_quats.size() == 0 && !start &&
             expected_angles.size() == 0) && cycles < CYCLE_LIMIT)
      @(posedge clk);
    while (settle < LATENCY + 10 && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      settle++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL quaternion_to_euler_top");
    end else if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("PASS quaternion_to_euler_top");
    end else begin
      $display("FAIL quaternion_to_euler_top");
    end
    $finish;
  end
endmodule
`default_nettype wire
